// ----- src/tbf_pkg.sv -----
// shared types and constants of the tlsf bitmap fit engine
package tbf_pkg;

   // field widths of the request and response beats
   localparam int CMD_W   = 3;
   localparam int SIZE_W  = 32;
   localparam int BIN_W   = 5;
   localparam int SUB_W   = 5;
   localparam int INDEX_W = 10;

   // second-level geometry
   localparam int SUB_COUNT = 32;

   // rounded request size carries one extra bit, lead position needs six
   localparam int RSIZE_W = SIZE_W + 1;
   localparam int LEAD_W  = 6;

   // smallest fit and allocation granule
   localparam int MIN_FIT    = 8;
   localparam int ALIGN_MASK = 7;

   // default size class geometry
   localparam int TOP_LEVELS_DEFAULT   = 24;
   localparam int LINEAR_LEVEL_DEFAULT = 7;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_FIND          = 3'd0,
      CMD_MARK_NONEMPTY = 3'd1,
      CMD_MARK_EMPTY    = 3'd2,
      CMD_INIT          = 3'd3,
      CMD_CLEAR         = 3'd4
   } cmd_type;

   // a (bin, sub) class and whether it is usable
   typedef struct packed {
      logic             ok;
      logic [BIN_W-1:0] bin;
      logic [SUB_W-1:0] sub;
   } class_type;

endpackage

// ----- src/tbf_if.sv -----
// valid/ready channels for request and response beats

interface tbf_req_if;
   import tbf_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [SIZE_W-1:0] block_size;

   modport source (output valid, output cmd, output block_size, input ready);
   modport sink   (input valid, input cmd, input block_size, output ready);
endinterface

interface tbf_rsp_if;
   import tbf_pkg::*;

   logic               valid;
   logic               ready;
   logic               ok;
   logic [BIN_W-1:0]   bin;
   logic [SUB_W-1:0]   sub;
   logic [INDEX_W-1:0] list_index;

   modport source (output valid, output ok, output bin, output sub, output list_index,
                   input ready);
   modport sink   (input valid, input ok, input bin, input sub, input list_index,
                   output ready);
endinterface

// ----- src/tlsf_bitmap_fit_engine_unit.sv -----
// top level of the tlsf bitmap fit engine: bitmaps, command decode and handshake
//
//   channel   dir   beat contents
//   req_bus   in    cmd, block_size
//   rsp_bus   out   ok, bin, sub, list_index
//
// one request beat per cycle while responses are taken; a request moves from the request register
// through mapping, search and bitmap update into the response register
// each command sees the bitmaps as left by the one before it
// reset clears both bitmap levels and both valid flags
// a stalled response holds the pipeline; one request may wait in the input register
module tlsf_bitmap_fit_engine_unit #(
   parameter int TOP_LEVELS   = tbf_pkg::TOP_LEVELS_DEFAULT,
   parameter int LINEAR_LEVEL = tbf_pkg::LINEAR_LEVEL_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   tbf_req_if.sink  req_bus,
   tbf_rsp_if.source rsp_bus
);
   import tbf_pkg::*;

   localparam int LEVELS = TOP_LEVELS - LINEAR_LEVEL + 1;
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam logic [BIN_W-1:0] LIN_BIN = BIN_W'(LINEAR_LEVEL - 1);

   // input register
   logic              req_valid_ff, req_valid_in;
   logic [CMD_W-1:0]  req_cmd_ff, req_cmd_in;
   logic [SIZE_W-1:0] req_size_ff, req_size_in;

   // bitmaps
   logic [LEVELS-1:0]                fl_map_ff, fl_map_in;
   logic [LEVELS-1:0][SUB_COUNT-1:0] sl_maps_ff, sl_maps_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [BIN_W-1:0]   rsp_bin_ff, rsp_bin_in;
   logic [SUB_W-1:0]   rsp_sub_ff, rsp_sub_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic               fire;
   logic               req_take;
   cmd_type            cmd;
   logic [RSIZE_W-1:0] fit_size;
   logic [RSIZE_W-1:0] map_size;
   logic               round_up;
   class_type          map_cls;
   class_type          fit_cls;
   class_type          res_cls;
   logic [BIN_W-1:0]   res_off;
   logic [BIN_W-1:0]   mark_off;
   logic [LVL_W-1:0]   mark_lvl;
   logic [SUB_COUNT-1:0] cleared;

   // handshake: the working stage moves when the response register is free
   assign fire          = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || fire;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign cmd = cmd_type'(req_cmd_ff);

   // size fed to the mapper: find requests are clamped and rounded to the granule, marks use the raw size
   always_comb begin
      if (req_size_ff == '0) begin
         fit_size = '0;
      end else if (req_size_ff < SIZE_W'(MIN_FIT)) begin
         fit_size = RSIZE_W'(MIN_FIT);
      end else begin
         fit_size = (RSIZE_W'(req_size_ff) + RSIZE_W'(ALIGN_MASK)) & ~RSIZE_W'(ALIGN_MASK);
      end
      round_up = (cmd == CMD_FIND);
      map_size = round_up ? fit_size : RSIZE_W'(req_size_ff);
   end

   tbf_map #(
      .TOP_LEVELS   (TOP_LEVELS),
      .LINEAR_LEVEL (LINEAR_LEVEL)
   ) u_map (
      .size     (map_size),
      .round_up (round_up),
      .cls      (map_cls)
   );

   tbf_search #(
      .TOP_LEVELS   (TOP_LEVELS),
      .LINEAR_LEVEL (LINEAR_LEVEL),
      .LEVELS       (LEVELS),
      .LVL_W        (LVL_W)
   ) u_search (
      .start   (map_cls),
      .fl_map  (fl_map_ff),
      .sl_maps (sl_maps_ff),
      .found   (fit_cls)
   );

   // level addressed by the mark commands
   assign mark_off = map_cls.bin - LIN_BIN;
   assign mark_lvl = mark_off[LVL_W-1:0];
   assign cleared  = sl_maps_ff[mark_lvl] & ~(SUB_COUNT'(1) << map_cls.sub);

   // bitmap update
   always_comb begin
      fl_map_in  = fl_map_ff;
      sl_maps_in = sl_maps_ff;
      if (fire) begin
         case (cmd)
            CMD_MARK_NONEMPTY: begin
               if (map_cls.ok) begin
                  fl_map_in[mark_lvl]                = 1'b1;
                  sl_maps_in[mark_lvl][map_cls.sub] = 1'b1;
               end
            end
            CMD_MARK_EMPTY: begin
               if (map_cls.ok) begin
                  sl_maps_in[mark_lvl] = cleared;
                  if (cleared == '0) begin
                     fl_map_in[mark_lvl] = 1'b0;
                  end
               end
            end
            CMD_INIT: begin
               sl_maps_in                           = '0;
               fl_map_in                            = '0;
               fl_map_in[LEVELS-1]                  = 1'b1;
               sl_maps_in[LEVELS-1][SUB_COUNT-1]    = 1'b1;
            end
            CMD_CLEAR: begin
               sl_maps_in = '0;
               fl_map_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // response contents
   always_comb begin
      res_cls   = '0;
      rsp_ok_in = 1'b0;
      case (cmd)
         CMD_FIND: begin
            rsp_ok_in = fit_cls.ok;
            res_cls   = fit_cls;
         end
         CMD_MARK_NONEMPTY, CMD_MARK_EMPTY: begin
            rsp_ok_in = map_cls.ok;
            res_cls   = map_cls;
         end
         CMD_INIT, CMD_CLEAR: begin
            rsp_ok_in = 1'b1;
         end
         default: begin
         end
      endcase
      if (!res_cls.ok) begin
         res_cls = '0;
      end
      res_off      = res_cls.bin - LIN_BIN;
      rsp_bin_in   = res_cls.bin;
      rsp_sub_in   = res_cls.sub;
      rsp_index_in = res_cls.ok ? {res_off, res_cls.sub} : '0;
   end

   // register next values
   always_comb begin
      req_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : req_valid_ff);
      req_cmd_in   = req_take ? req_bus.cmd : req_cmd_ff;
      req_size_in  = req_take ? req_bus.block_size : req_size_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   // control and bitmap registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fl_map_ff    <= '0;
         sl_maps_ff   <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fl_map_ff    <= fl_map_in;
         sl_maps_ff   <= sl_maps_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_cmd_ff  <= req_cmd_in;
      req_size_ff <= req_size_in;
      if (fire) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_bin_ff   <= rsp_bin_in;
         rsp_sub_ff   <= rsp_sub_in;
         rsp_index_ff <= rsp_index_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.ok         = rsp_ok_ff;
   assign rsp_bus.bin        = rsp_bin_ff;
   assign rsp_bus.sub        = rsp_sub_ff;
   assign rsp_bus.list_index = rsp_index_ff;

endmodule

// ----- src/tbf_map.sv -----
// maps a byte size to its (bin, sub) size class, rounding up or truncating
module tbf_map #(
   parameter int TOP_LEVELS   = tbf_pkg::TOP_LEVELS_DEFAULT,
   parameter int LINEAR_LEVEL = tbf_pkg::LINEAR_LEVEL_DEFAULT
) (
   input  logic [tbf_pkg::RSIZE_W-1:0] size,
   input  logic                        round_up,
   output tbf_pkg::class_type          cls
);
   import tbf_pkg::*;

   localparam logic [LEAD_W-1:0] TOP_L   = LEAD_W'(TOP_LEVELS);
   localparam logic [LEAD_W-1:0] LIN_L   = LEAD_W'(LINEAR_LEVEL);
   localparam logic [LEAD_W-1:0] LIN_BIN = LEAD_W'(LINEAR_LEVEL - 1);
   localparam logic [LEAD_W-1:0] SUB_L   = LEAD_W'(SUB_W);

   logic [LEAD_W-1:0]  lead;
   logic               linear;
   logic [LEAD_W-1:0]  width;
   logic [LEAD_W-1:0]  shift;
   logic [RSIZE_W-1:0] excess;
   logic [RSIZE_W-1:0] rem_mask;
   logic               has_rem;
   logic [SUB_W:0]     sub_sum;
   logic [LEAD_W-1:0]  lead_fin;
   logic [SUB_W-1:0]   sub_fin;

   // leading one position
   always_comb begin
      lead = '0;
      for (int i = 0; i < RSIZE_W; i++) begin
         if (size[i]) begin
            lead = LEAD_W'(i);
         end
      end
   end

   // class split: linear zone or power-of-two bin
   always_comb begin
      linear   = (lead < LIN_L);
      width    = linear ? LIN_L : lead;
      excess   = linear ? size : (size & ~(RSIZE_W'(1) << lead));
      shift    = (width >= SUB_L) ? (width - SUB_L) : '0;
      rem_mask = (RSIZE_W'(1) << shift) - RSIZE_W'(1);
      has_rem  = |(excess & rem_mask);
      sub_sum  = {1'b0, SUB_W'(excess >> shift)} + (SUB_W+1)'(round_up && has_rem);
      lead_fin = linear ? LIN_BIN : lead;
      sub_fin  = sub_sum[SUB_W-1:0];
      // rounding past the last sub-list moves to the next bin
      if (sub_sum[SUB_W]) begin
         lead_fin = lead_fin + LEAD_W'(1);
      end
   end

   // zero size or an oversized class gives no mapping
   always_comb begin
      cls.ok  = (size != '0) && (lead < TOP_L) && (lead_fin < TOP_L);
      cls.bin = lead_fin[BIN_W-1:0];
      cls.sub = sub_fin;
   end

endmodule

// ----- src/tbf_search.sv -----
// finds the first non-empty free list at or above a starting class
module tbf_search #(
   parameter int TOP_LEVELS   = tbf_pkg::TOP_LEVELS_DEFAULT,
   parameter int LINEAR_LEVEL = tbf_pkg::LINEAR_LEVEL_DEFAULT,
   parameter int LEVELS       = TOP_LEVELS - LINEAR_LEVEL + 1,
   parameter int LVL_W        = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
   input  tbf_pkg::class_type                            start,
   input  logic [LEVELS-1:0]                             fl_map,
   input  logic [LEVELS-1:0][tbf_pkg::SUB_COUNT-1:0]     sl_maps,
   output tbf_pkg::class_type                            found
);
   import tbf_pkg::*;

   localparam logic [BIN_W-1:0] LIN_BIN = BIN_W'(LINEAR_LEVEL - 1);

   logic [BIN_W-1:0]                    start_off;
   logic [LVL_W-1:0]                    start_lvl;
   logic [SUB_COUNT-1:0]                start_mask;
   logic [LEVELS-1:0][SUB_COUNT-1:0]    masked;
   logic [LEVELS-1:0]                   cand;
   logic                                hit;
   logic [LVL_W-1:0]                    sel;
   logic [SUB_COUNT-1:0]                word;
   logic [SUB_W-1:0]                    low;

   // candidate lists per level, the starting level masked below its sub
   always_comb begin
      start_off  = start.bin - LIN_BIN;
      start_lvl  = start_off[LVL_W-1:0];
      start_mask = {SUB_COUNT{1'b1}} << start.sub;
      for (int k = 0; k < LEVELS; k++) begin
         masked[k] = (LVL_W'(k) == start_lvl) ? (sl_maps[k] & start_mask) : sl_maps[k];
         cand[k]   = (LVL_W'(k) >= start_lvl) && fl_map[k] && (|masked[k]);
      end
   end

   // lowest candidate level
   always_comb begin
      hit = 1'b0;
      sel = '0;
      for (int k = LEVELS - 1; k >= 0; k--) begin
         if (cand[k]) begin
            hit = 1'b1;
            sel = LVL_W'(k);
         end
      end
   end

   // lowest set sub-list within the chosen level
   always_comb begin
      word = masked[sel];
      low  = '0;
      for (int b = SUB_COUNT - 1; b >= 0; b--) begin
         if (word[b]) begin
            low = SUB_W'(b);
         end
      end
      found.ok  = start.ok && hit;
      found.bin = BIN_W'(sel) + LIN_BIN;
      found.sub = low;
   end

endmodule

// ----- bench/tb.sv -----
// self-checking bench for the tlsf bitmap fit engine, directed and random command beats
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tbf_pkg::*;

   localparam int LIN_BIN    = LINEAR_LEVEL_DEFAULT - 1;
   localparam int LEVELS     = TOP_LEVELS_DEFAULT - LINEAR_LEVEL_DEFAULT + 1;
   localparam int CMD_MAX    = (1 << CMD_W) - 1;
   localparam int DRAIN_WAIT = 8;

   // one expected response beat
   typedef struct {
      logic               ok;
      logic [BIN_W-1:0]   bin;
      logic [SUB_W-1:0]   sub;
      logic [INDEX_W-1:0] list_index;
   } fit_answer_type;

   logic clock;
   logic reset;

   tbf_req_if req_bus ();
   tbf_rsp_if rsp_bus ();

   tlsf_bitmap_fit_engine_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // bench copy of both bitmap levels
   logic [LEVELS-1:0] bin_map;
   logic [31:0]       sub_maps [LEVELS];

   fit_answer_type    expected_fits [$];
   logic [SIZE_W-1:0] marked_sizes [$];
   int                mismatches;
   int                send_idle_pct;
   int                recv_idle_pct;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // maps a size to (bin, sub), rounding up or truncating
   function automatic bit size_to_class(input logic [SIZE_W:0] sz, input bit up,
                                        output int unsigned cls_bin,
                                        output int unsigned cls_sub);
      int             lead;
      int             width;
      int             sh;
      int             i;
      int unsigned    sb;
      logic [SIZE_W:0] excess;
      cls_bin = 0;
      cls_sub = 0;
      if (sz == '0) return 1'b0;
      lead = 0;
      for (i = 0; i <= SIZE_W; i++) begin
         if (sz[i]) lead = i;
      end
      if (lead >= TOP_LEVELS_DEFAULT) return 1'b0;
      if (lead < LINEAR_LEVEL_DEFAULT) begin
         lead   = LIN_BIN;
         width  = LINEAR_LEVEL_DEFAULT;
         excess = sz;
      end else begin
         width  = lead;
         excess = sz - ((SIZE_W+1)'(1) << lead);
      end
      sh = (width >= SUB_W) ? width - SUB_W : 0;
      sb = int'(excess >> sh);
      // round up into the next sub-list, possibly the next bin
      if (up && (excess & (((SIZE_W+1)'(1) << sh) - 1)) != '0) begin
         sb++;
         if (sb >= SUB_COUNT) begin
            sb = 0;
            lead++;
         end
      end
      if (lead >= TOP_LEVELS_DEFAULT) return 1'b0;
      cls_bin = lead;
      cls_sub = sb & (SUB_COUNT - 1);
      return 1'b1;
   endfunction

   // applies one command to the bitmap copy and returns the response it should give
   function automatic fit_answer_type predict_fit(input logic [CMD_W-1:0] op,
                                                  input logic [SIZE_W-1:0] size);
      fit_answer_type  ans;
      logic [SIZE_W:0] rsize;
      int unsigned     cls_bin;
      int unsigned     cls_sub;
      int unsigned     lvl;
      int unsigned     start;
      int unsigned     bitpos;
      logic [31:0]     m;
      bit              hit;
      ans.ok         = 1'b0;
      ans.bin        = '0;
      ans.sub        = '0;
      ans.list_index = '0;
      hit            = 1'b0;
      case (op)
         CMD_FIND: begin
            if (size != '0) begin
               rsize = (size < MIN_FIT) ? (SIZE_W+1)'(MIN_FIT) : {1'b0, size};
               rsize = (rsize + ALIGN_MASK) & ~(SIZE_W+1)'(ALIGN_MASK);
               if (size_to_class(rsize, 1'b1, cls_bin, cls_sub)) begin
                  // first non-empty list at or above the class
                  start = cls_sub;
                  for (lvl = cls_bin - LIN_BIN; lvl < LEVELS && !hit; lvl++) begin
                     if (bin_map[lvl]) begin
                        m = sub_maps[lvl] >> start;
                        if (m != '0) begin
                           bitpos = 0;
                           while (!m[bitpos]) bitpos++;
                           cls_bin = lvl + LIN_BIN;
                           cls_sub = start + bitpos;
                           hit     = 1'b1;
                        end
                     end
                     start = 0;
                  end
               end
            end
         end
         CMD_MARK_NONEMPTY, CMD_MARK_EMPTY: begin
            if (size_to_class({1'b0, size}, 1'b0, cls_bin, cls_sub)) begin
               lvl = cls_bin - LIN_BIN;
               if (op == CMD_MARK_NONEMPTY) begin
                  bin_map[lvl]           = 1'b1;
                  sub_maps[lvl][cls_sub] = 1'b1;
               end else begin
                  sub_maps[lvl][cls_sub] = 1'b0;
                  if (sub_maps[lvl] == '0) bin_map[lvl] = 1'b0;
               end
               hit = 1'b1;
            end
         end
         CMD_INIT: begin
            foreach (sub_maps[k]) sub_maps[k] = '0;
            bin_map                    = '0;
            bin_map[LEVELS-1]          = 1'b1;
            sub_maps[LEVELS-1]         = 32'd1 << (SUB_COUNT - 1);
            ans.ok                     = 1'b1;
         end
         CMD_CLEAR: begin
            foreach (sub_maps[k]) sub_maps[k] = '0;
            bin_map = '0;
            ans.ok  = 1'b1;
         end
         default: ;
      endcase
      if (hit) begin
         ans.ok         = 1'b1;
         ans.bin        = BIN_W'(cls_bin);
         ans.sub        = SUB_W'(cls_sub);
         ans.list_index = INDEX_W'((cls_bin - LIN_BIN) * SUB_COUNT + cls_sub);
      end
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
   endtask

   // drives one request beat and records its expected response once accepted
   task automatic send_beat(input logic [CMD_W-1:0] op, input logic [SIZE_W-1:0] size);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= op;
      req_bus.block_size <= size;
      do @(posedge clock); while (!req_bus.ready);
      expected_fits.push_back(predict_fit(op, size));
   endtask

   // random size, mostly below the top class, with a few zeros
   function automatic logic [SIZE_W-1:0] rand_size();
      int unsigned       r;
      int unsigned       lead;
      logic [SIZE_W-1:0] one;
      one = 1;
      r   = $urandom_range(0, 99);
      if (r < 3) return '0;
      if (r < 90) lead = $urandom_range(0, TOP_LEVELS_DEFAULT - 1);
      else lead = $urandom_range(TOP_LEVELS_DEFAULT, SIZE_W - 1);
      return (one << lead) | ($urandom & ((one << lead) - 1));
   endfunction

   // empty bitmaps: zero sizes, nothing fits, unknown commands
   task automatic test_empty_maps();
      send_beat(CMD_FIND, 32'd0);
      send_beat(CMD_FIND, 32'd1);
      send_beat(CMD_MARK_NONEMPTY, 32'd0);
      send_beat(CMD_MARK_EMPTY, 32'd0);
      send_beat(CMD_W'(CMD_CLEAR + 1), 32'hFFFF_FFFF);
   endtask

   // init leaves the top list, oversize requests and marks fail
   task automatic test_init_top();
      send_beat(CMD_INIT, 32'd0);
      send_beat(CMD_FIND, 32'd1);
      send_beat(CMD_FIND, 32'h00FF_FFF8);
      send_beat(CMD_FIND, 32'hFFFF_FFFF);
      send_beat(CMD_FIND, 32'h007F_FFFF);
      send_beat(CMD_MARK_NONEMPTY, 32'h0100_0000);
   endtask

   // tiny requests and the linear zone edges
   task automatic test_linear_zone();
      send_beat(CMD_CLEAR, 32'd0);
      send_beat(CMD_MARK_NONEMPTY, 32'd8);
      send_beat(CMD_FIND, 32'd1);
      send_beat(CMD_FIND, 32'd9);
      send_beat(CMD_MARK_NONEMPTY, 32'd127);
      send_beat(CMD_FIND, 32'd120);
      send_beat(CMD_MARK_NONEMPTY, 32'd128);
      send_beat(CMD_FIND, 32'd121);
   endtask

   // emptying the last sub-list drops the bin bit
   task automatic test_mark_empty();
      send_beat(CMD_MARK_EMPTY, 32'd8);
      send_beat(CMD_MARK_EMPTY, 32'd127);
      send_beat(CMD_FIND, 32'd1);
      send_beat(CMD_MARK_EMPTY, 32'd128);
      send_beat(CMD_FIND, 32'd1);
   endtask

   // mostly mark/find/unmark traffic on live sizes, with init, clear and noise
   task automatic test_random_traffic(input int count);
      int                done;
      int unsigned       roll;
      int unsigned       pick;
      logic [SIZE_W-1:0] size;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(0, 99);
         size = rand_size();
         if (roll < 38) begin
            if ($urandom_range(0, 9) == 0) size = $urandom_range(1, MIN_FIT);
            send_beat(CMD_FIND, size);
            done++;
         end else if (roll < 68) begin
            send_beat(CMD_MARK_NONEMPTY, size);
            if (size != '0 && marked_sizes.size() < 64) marked_sizes.push_back(size);
            done++;
         end else if (roll < 95) begin
            if (marked_sizes.size() != 0 && $urandom_range(0, 4) != 0) begin
               pick = $urandom_range(0, marked_sizes.size() - 1);
               size = marked_sizes[pick];
               marked_sizes.delete(pick);
            end
            send_beat(CMD_MARK_EMPTY, size);
            done++;
         end else if (roll < 97) begin
            send_beat(CMD_INIT, size);
            marked_sizes.delete();
            done++;
         end else if (roll < 98) begin
            send_beat(CMD_CLEAR, size);
            marked_sizes.delete();
            done++;
         end else begin
            send_beat(CMD_W'($urandom_range(CMD_CLEAR + 1, CMD_MAX)), size);
         end
      end
   endtask

   // response side backpressure
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      fit_answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_fits.size() == 0) begin
            report_mismatch("response with none pending", 32'(rsp_bus.ok), 0);
         end else begin
            want = expected_fits.pop_front();
            if (rsp_bus.ok !== want.ok)
               report_mismatch("ok", 32'(rsp_bus.ok), 32'(want.ok));
            if (rsp_bus.bin !== want.bin)
               report_mismatch("bin", 32'(rsp_bus.bin), 32'(want.bin));
            if (rsp_bus.sub !== want.sub)
               report_mismatch("sub", 32'(rsp_bus.sub), 32'(want.sub));
            if (rsp_bus.list_index !== want.list_index)
               report_mismatch("list_index", 32'(rsp_bus.list_index),
                               32'(want.list_index));
         end
      end
   end

   // run limit
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // main sequence
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_FIND;
      req_bus.block_size = '0;
      bin_map            = '0;
      foreach (sub_maps[k]) sub_maps[k] = '0;
      mismatches         = 0;
      send_idle_pct      = 33;
      recv_idle_pct      = 46;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_maps();
      test_init_top();
      test_linear_zone();
      test_mark_empty();
      test_random_traffic(650);

      send_idle_pct = 46;
      recv_idle_pct = 33;
      test_random_traffic(650);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(650);

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // drain, then wait for stray beats
      while (expected_fits.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
